FILE: hdl/lsra_pkg.sv
// ============================================================================
// Linear scan allocator package
// Shared word types and field widths of the linear scan register allocator.
// ============================================================================
package lsra_pkg;

    localparam int STMT_W = 12;
    localparam int VREG_W = 6;
    localparam int PEAK_W = 7;

    // Input word: one usage record or a finish request.
    typedef struct packed {
        logic              command;
        logic [STMT_W-1:0] stmt_index;
        logic [VREG_W-1:0] vreg;
    } item_t;

    // Result word: the allocation of one virtual register.
    typedef struct packed {
        logic [VREG_W-1:0] vreg_out;
        logic [VREG_W-1:0] phys_reg;
        logic [PEAK_W-1:0] peak_regs;
        logic              any_used;
        logic              last;
    } result_t;

    localparam logic CMD_USE    = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

endpackage

FILE: hdl/lsra_ram.sv
// ============================================================================
// Generic RAM
// Single write port, single read port with a registered read.
// ============================================================================
module lsra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/lsra_out.sv
// ============================================================================
// Result output stage
// Holds one result word until the receiver takes it.
// ============================================================================
module lsra_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  lsra_pkg::result_t word,
    output logic              free,
    output logic              result_valid,
    input  logic              result_stall,
    output lsra_pkg::result_t result
);

    import lsra_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t word_reg;

    // The stage can take a new word when empty or when its word leaves now.
    assign free = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word;
        end
    end

    assign result_valid = valid_reg;
    assign result       = word_reg;

endmodule

FILE: hdl/linear_scan_register_allocator.sv
// ============================================================================
// Linear scan register allocator
// Records live intervals of virtual registers and assigns physical registers.
// ============================================================================
// Usage: the item channel carries words that either record one usage of a
// virtual register at a statement, or request a finish. A usage word is
// accepted, then a read-modify-write of the interval tables follows; out of
// range usages are dropped on acceptance. A finish word runs the allocation
// under a small sequencer: for each of the used registers it scans the table
// for the earliest start, scans the live intervals for expiry and walks the
// busy flags for the lowest free physical register, then makes one last
// start scan and an emission walk over the registers up to the highest used
// one, emitting a result for each used one. Results leave in virtual register
// order through an output register; the final one carries last. With nothing
// used a single word with only last set is sent. item_stall stays high from a
// finish until its last result has been loaded; a stalled receiver simply
// holds the sequencer at the load.
// Reset clears all flags and counters; the interval RAMs need no clearing, as
// an entry's contents are only used once it has been written since the last finish.
// ============================================================================
module linear_scan_register_allocator #(
    parameter int NUM_VREGS = 64,
    parameter int MAX_STMTS = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  lsra_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output lsra_pkg::result_t result
);

    import lsra_pkg::*;

    localparam int VW = (NUM_VREGS > 1) ? $clog2(NUM_VREGS) : 1;
    localparam logic [VW-1:0] LAST_IDX = VW'(NUM_VREGS - 1);
    localparam logic [VREG_W:0] VREG_LIMIT = (VREG_W + 1)'(NUM_VREGS);
    localparam logic [16:0] STMT_LIMIT = 17'(MAX_STMTS);

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_UPD       = 9'b000000010,
        S_MIN_RD    = 9'b000000100,
        S_MIN_EVAL  = 9'b000001000,
        S_MIN_END   = 9'b000010000,
        S_FREE_RD   = 9'b000100000,
        S_FREE_EVAL = 9'b001000000,
        S_FIND      = 9'b010000000,
        S_EMIT      = 9'b100000000
    } state_t;

    // Emission needs a read state too; it is kept as a separate flag outside the
    // one-hot encoding so that read and load alternate within S_EMIT.
    state_t state_reg, state_next;

    logic [VW-1:0]        idx_reg, idx_next;
    logic [VW-1:0]        pick_reg, pick_next;
    logic                 found_reg, found_next;
    logic [STMT_W-1:0]    best_reg, best_next;
    logic [STMT_W-1:0]    stmt_reg, stmt_next;
    logic [VW-1:0]        vreg_reg, vreg_next;
    logic [NUM_VREGS-1:0] seen_reg, seen_next;
    logic [NUM_VREGS-1:0] live_reg, live_next;
    logic [NUM_VREGS-1:0] busy_reg, busy_next;
    logic [NUM_VREGS-1:0] done_reg, done_next;
    logic [PEAK_W-1:0]    peak_reg, peak_next;
    logic                 any_seen_reg, any_seen_next;
    logic [VW-1:0]        max_vreg_reg, max_vreg_next;
    logic                 emit_ld_reg, emit_ld_next;

    // Table RAM ports.
    logic              first_we, last_we, asgn_we;
    logic              first_re, last_re, asgn_re;
    logic [VW-1:0]     rd_addr;
    logic [STMT_W-1:0] first_wd, last_wd;
    logic [STMT_W-1:0] first_rd, last_rd;
    logic [VW-1:0]     asgn_rd;

    logic    accept;
    logic    in_range;
    logic    had_seen;
    logic    out_load;
    logic    out_free;
    logic    emit_final;
    result_t out_word;

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && (state_reg == S_IDLE);
    assign in_range   = ((VREG_W + 1)'(item.vreg) < VREG_LIMIT) &&
                        (17'(item.stmt_index) < STMT_LIMIT);
    assign rd_addr    = (state_reg == S_IDLE) ? item.vreg[VW-1:0] : idx_reg;
    assign had_seen   = seen_reg[vreg_reg];
    assign emit_final = !any_seen_reg || (idx_reg == max_vreg_reg);

    // A usage widens the interval; a first usage opens it at this statement.
    assign first_wd = (!had_seen || (stmt_reg < first_rd)) ? stmt_reg : first_rd;
    assign last_wd  = (!had_seen || (stmt_reg > last_rd)) ? stmt_reg : last_rd;

    always_comb
    begin
        out_word = '0;
        if (any_seen_reg)
        begin
            out_word.vreg_out  = VREG_W'(idx_reg);
            out_word.phys_reg  = VREG_W'(asgn_rd);
            out_word.peak_regs = peak_reg;
            out_word.any_used  = 1'b1;
        end
        out_word.last = emit_final;
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        pick_next     = pick_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        stmt_next     = stmt_reg;
        vreg_next     = vreg_reg;
        seen_next     = seen_reg;
        live_next     = live_reg;
        busy_next     = busy_reg;
        done_next     = done_reg;
        peak_next     = peak_reg;
        any_seen_next = any_seen_reg;
        max_vreg_next = max_vreg_reg;
        emit_ld_next  = emit_ld_reg;
        first_we      = 1'b0;
        last_we       = 1'b0;
        asgn_we       = 1'b0;
        first_re      = 1'b0;
        last_re       = 1'b0;
        asgn_re       = 1'b0;
        out_load      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.command == CMD_FINISH)
                    begin
                        idx_next   = '0;
                        found_next = 1'b0;
                        state_next = S_MIN_RD;
                    end
                    else if (in_range)
                    begin
                        stmt_next  = item.stmt_index;
                        vreg_next  = item.vreg[VW-1:0];
                        first_re   = 1'b1;
                        last_re    = 1'b1;
                        state_next = S_UPD;
                    end
                end
            end

            S_UPD:
            begin
                first_we            = 1'b1;
                last_we             = 1'b1;
                seen_next[vreg_reg] = 1'b1;
                any_seen_next       = 1'b1;
                if (!any_seen_reg || (vreg_reg > max_vreg_reg))
                begin
                    max_vreg_next = vreg_reg;
                end
                state_next = S_IDLE;
            end

            S_MIN_RD:
            begin
                if (seen_reg[idx_reg] && !done_reg[idx_reg])
                begin
                    first_re   = 1'b1;
                    state_next = S_MIN_EVAL;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = S_MIN_END;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_MIN_EVAL:
            begin
                // Strict compare keeps the lower register on equal starts.
                if (!found_reg || (first_rd < best_reg))
                begin
                    pick_next  = idx_reg;
                    best_next  = first_rd;
                    found_next = 1'b1;
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_MIN_END;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_MIN_RD;
                end
            end

            S_MIN_END:
            begin
                idx_next = '0;
                if (found_reg)
                begin
                    done_next[pick_reg] = 1'b1;
                    state_next          = S_FREE_RD;
                end
                else
                begin
                    emit_ld_next = !any_seen_reg;
                    state_next   = S_EMIT;
                end
            end

            S_FREE_RD:
            begin
                if (live_reg[idx_reg])
                begin
                    last_re    = 1'b1;
                    asgn_re    = 1'b1;
                    state_next = S_FREE_EVAL;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_FIND;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_FREE_EVAL:
            begin
                // An interval ending where the new one starts stays live.
                if (last_rd < best_reg)
                begin
                    live_next[idx_reg] = 1'b0;
                    busy_next[asgn_rd] = 1'b0;
                end
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_FIND;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FREE_RD;
                end
            end

            S_FIND:
            begin
                if (!busy_reg[idx_reg])
                begin
                    busy_next[idx_reg]  = 1'b1;
                    live_next[pick_reg] = 1'b1;
                    asgn_we             = 1'b1;
                    if (peak_reg < (PEAK_W'(idx_reg) + 1'b1))
                    begin
                        peak_next = PEAK_W'(idx_reg) + 1'b1;
                    end
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = S_MIN_RD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_EMIT:
            begin
                if (!emit_ld_reg)
                begin
                    if (seen_reg[idx_reg])
                    begin
                        asgn_re      = 1'b1;
                        emit_ld_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (out_free)
                begin
                    out_load     = 1'b1;
                    emit_ld_next = 1'b0;
                    if (emit_final)
                    begin
                        // Finish run over: tables start afresh.
                        seen_next     = '0;
                        live_next     = '0;
                        busy_next     = '0;
                        done_next     = '0;
                        peak_next     = '0;
                        any_seen_next = 1'b0;
                        max_vreg_next = '0;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            seen_reg     <= '0;
            live_reg     <= '0;
            busy_reg     <= '0;
            done_reg     <= '0;
            peak_reg     <= '0;
            any_seen_reg <= 1'b0;
            max_vreg_reg <= '0;
            emit_ld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            found_reg    <= found_next;
            seen_reg     <= seen_next;
            live_reg     <= live_next;
            busy_reg     <= busy_next;
            done_reg     <= done_next;
            peak_reg     <= peak_next;
            any_seen_reg <= any_seen_next;
            max_vreg_reg <= max_vreg_next;
            emit_ld_reg  <= emit_ld_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        pick_reg <= pick_next;
        best_reg <= best_next;
        stmt_reg <= stmt_next;
        vreg_reg <= vreg_next;
    end

    // Interval start table.
    lsra_ram #(
        .WIDTH (STMT_W),
        .DEPTH (NUM_VREGS)
    ) u_first_ram (
        .clk     (clk),
        .wr_en   (first_we),
        .wr_addr (vreg_reg),
        .wr_data (first_wd),
        .rd_en   (first_re),
        .rd_addr (rd_addr),
        .rd_data (first_rd)
    );

    // Interval end table.
    lsra_ram #(
        .WIDTH (STMT_W),
        .DEPTH (NUM_VREGS)
    ) u_last_ram (
        .clk     (clk),
        .wr_en   (last_we),
        .wr_addr (vreg_reg),
        .wr_data (last_wd),
        .rd_en   (last_re),
        .rd_addr (rd_addr),
        .rd_data (last_rd)
    );

    // Physical register given to each interval.
    lsra_ram #(
        .WIDTH (VW),
        .DEPTH (NUM_VREGS)
    ) u_asgn_ram (
        .clk     (clk),
        .wr_en   (asgn_we),
        .wr_addr (pick_reg),
        .wr_data (idx_reg),
        .rd_en   (asgn_re),
        .rd_addr (rd_addr),
        .rd_data (asgn_rd)
    );

    lsra_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (out_load),
        .word         (out_word),
        .free         (out_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // The count of occupied physical registers matches the count of live intervals.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(busy_reg) == $countones(live_reg))
        else $error("busy and live counts differ");

    // The peak always covers every occupied physical register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(busy_reg) <= int'(peak_reg))
        else $error("peak below occupied count");

    // Only recorded registers can have been allocated.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg & ~seen_reg) == '0)
        else $error("allocated register never recorded");

    // Loading the final word of a finish run returns to idle with empty tables.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && emit_final) |=> (state_reg == S_IDLE) && (seen_reg == '0))
        else $error("finish run did not close cleanly");

endmodule

FILE: tb/lsra_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Linear scan allocator checker
// Watches both channels of the allocator, keeps its own interval tables from
// the accepted usage words, works out the allocation on every finish word and
// compares each accepted result word field by field with the oldest one due.
// ============================================================================
module lsra_checker #(
    parameter int NUM_VREGS = 64,
    parameter int MAX_STMTS = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  lsra_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  lsra_pkg::result_t result,
    output int                fail_count,
    output int                words_due
);

    import lsra_pkg::*;

    logic [STMT_W-1:0] first_stmt [NUM_VREGS];
    logic [STMT_W-1:0] last_stmt  [NUM_VREGS];
    bit                touched    [NUM_VREGS];
    result_t           allocations_due [$];
    int                mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string line);
        mismatches++;
        $display("%0t ns: %s", $time, line);
    endtask

    function automatic void forget_intervals();
        for (int v = 0; v < NUM_VREGS; v++)
            touched[v] = 1'b0;
    endfunction

    // Widen the live interval of one virtual register; words outside the
    // configured register or statement range are dropped.
    function automatic void note_usage(input item_t w);
        if (w.vreg < NUM_VREGS && w.stmt_index < MAX_STMTS)
        begin
            if (!touched[w.vreg])
            begin
                touched[w.vreg]    = 1'b1;
                first_stmt[w.vreg] = w.stmt_index;
                last_stmt[w.vreg]  = w.stmt_index;
            end
            else
            begin
                if (w.stmt_index < first_stmt[w.vreg])
                    first_stmt[w.vreg] = w.stmt_index;
                if (w.stmt_index > last_stmt[w.vreg])
                    last_stmt[w.vreg] = w.stmt_index;
            end
        end
    endfunction

    // Linear scan over the recorded intervals, then queue one result word per
    // used register in register order and clear the tables.
    function automatic void run_linear_scan();
        bit      done     [NUM_VREGS];
        bit      active   [NUM_VREGS];
        bit      occupied [NUM_VREGS];
        int      phys_of  [NUM_VREGS];
        int      peak;
        int      pick;
        int      free_reg;
        int      total;
        int      emitted;
        result_t r;

        peak    = 0;
        total   = 0;
        emitted = 0;
        for (int v = 0; v < NUM_VREGS; v++)
        begin
            done[v]     = 1'b0;
            active[v]   = 1'b0;
            occupied[v] = 1'b0;
            phys_of[v]  = 0;
            if (touched[v])
                total++;
        end

        for (int round = 0; round < NUM_VREGS; round++)
        begin
            // Earliest start first; a strict compare keeps the lower register on a tie.
            pick = -1;
            for (int v = 0; v < NUM_VREGS; v++)
                if (touched[v] && !done[v] &&
                    (pick < 0 || first_stmt[v] < first_stmt[pick]))
                    pick = v;
            if (pick < 0)
                break;
            done[pick] = 1'b1;

            // Only intervals that ended strictly before this start are released.
            for (int k = 0; k < NUM_VREGS; k++)
                if (active[k] && last_stmt[k] < first_stmt[pick])
                begin
                    active[k]            = 1'b0;
                    occupied[phys_of[k]] = 1'b0;
                end

            free_reg = NUM_VREGS - 1;
            for (int p = NUM_VREGS - 1; p >= 0; p--)
                if (!occupied[p])
                    free_reg = p;
            occupied[free_reg] = 1'b1;
            phys_of[pick]      = free_reg;
            active[pick]       = 1'b1;
            if (free_reg + 1 > peak)
                peak = free_reg + 1;
        end

        for (int v = 0; v < NUM_VREGS; v++)
            if (touched[v])
            begin
                emitted++;
                r.vreg_out  = v[VREG_W-1:0];
                r.phys_reg  = phys_of[v][VREG_W-1:0];
                r.peak_regs = peak[PEAK_W-1:0];
                r.any_used  = 1'b1;
                r.last      = (emitted == total);
                allocations_due.push_back(r);
            end
        if (total == 0)
        begin
            r      = '0;
            r.last = 1'b1;
            allocations_due.push_back(r);
        end
        forget_intervals();
    endfunction

    task automatic check_result(input result_t got);
        result_t want;
        if (allocations_due.size() == 0)
            report_mismatch($sformatf("result word for vreg %0d with none outstanding",
                                      got.vreg_out));
        else
        begin
            want = allocations_due.pop_front();
            if (got.vreg_out !== want.vreg_out)
                report_mismatch($sformatf("vreg_out %0d, expected %0d",
                                          got.vreg_out, want.vreg_out));
            if (got.phys_reg !== want.phys_reg)
                report_mismatch($sformatf("vreg %0d: phys_reg %0d, expected %0d",
                                          want.vreg_out, got.phys_reg, want.phys_reg));
            if (got.peak_regs !== want.peak_regs)
                report_mismatch($sformatf("vreg %0d: peak_regs %0d, expected %0d",
                                          want.vreg_out, got.peak_regs, want.peak_regs));
            if (got.any_used !== want.any_used)
                report_mismatch($sformatf("vreg %0d: any_used %0b, expected %0b",
                                          want.vreg_out, got.any_used, want.any_used));
            if (got.last !== want.last)
                report_mismatch($sformatf("vreg %0d: last %0b, expected %0b",
                                          want.vreg_out, got.last, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forget_intervals();
            allocations_due.delete();
            words_due <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_result(result);
            if (item_valid && !item_stall)
            begin
                if (item.command == CMD_FINISH)
                    run_linear_scan();
                else
                    note_usage(item);
            end
            words_due <= allocations_due.size();
        end
    end

endmodule

FILE: tb/tb_linear_scan_register_allocator.sv
`timescale 1ns / 1ps
// ============================================================================
// Linear scan register allocator testbench
// Drives usage and finish words into the allocator with random idling on both
// channels; a checker beside the block predicts every allocation and compares
// the result words, and this module gives the verdict.
// ============================================================================
module tb_linear_scan_register_allocator;

    import lsra_pkg::*;

    localparam int NUM_VREGS     = 64;
    localparam int MAX_STMTS     = 4096;
    localparam int ITEM_TARGET   = 430;     // stimulus stops once this many words went in
    localparam int CALM_FROM     = 370;     // from here on neither side idles
    localparam int DRAIN_LIMIT   = 100000;  // cycles allowed for the final results
    localparam int SETTLE_CYCLES = 40;      // watch for stray words after the last one

    logic    clk;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    int      fail_count;
    int      words_due;

    // Set by nonblocking assignment so that the stall generator sees it
    // at the same edge however the processes are ordered.
    bit      calm       = 1'b0;
    int      words_sent = 0;
    int      hold_left  = 0;
    item_t   batch [$];

    linear_scan_register_allocator #(
        .NUM_VREGS (NUM_VREGS),
        .MAX_STMTS (MAX_STMTS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    lsra_checker #(
        .NUM_VREGS (NUM_VREGS),
        .MAX_STMTS (MAX_STMTS)
    ) alloc_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .words_due    (words_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The slowest correct run is a few milliseconds: every finish scanning
    // its tables several times per used register, plus every gap and stall.
    initial
    begin
        #20_000_000;
        $display("tb_linear_scan_register_allocator failed");
        $finish;
    end

    // The receiver stalls in random bursts, and not at all
    // once the run has reached its calm final stretch.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            hold_left = $urandom_range(0, 4);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    function automatic item_t use_word(input int stmt, input int vreg);
        item_t w;
        w.command    = CMD_USE;
        w.stmt_index = stmt[STMT_W-1:0];
        w.vreg       = vreg[VREG_W-1:0];
        return w;
    endfunction

    // The position and register of a finish word are ignored by the block,
    // so they carry random bits.
    function automatic item_t finish_word();
        item_t w;
        w.command    = CMD_FINISH;
        w.stmt_index = STMT_W'($urandom);
        w.vreg       = VREG_W'($urandom);
        return w;
    endfunction

    // Offer one word, after an optional idle burst, and hold it until the
    // block takes it.
    task automatic send_word(input item_t w);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        words_sent++;
        if (words_sent >= CALM_FROM)
            calm <= 1'b1;
    endtask

    // Hold the sender back until every predicted result word has come out.
    task automatic wait_for_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int    group;
        int    kind;
        int    count;
        int    span;
        int    base;
        int    prev_end;
        int    s;
        int    e;
        int    v;
        int    idx;
        int    settle;
        item_t w;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A finish with nothing recorded gives a single word with only last set.
        send_word(finish_word());

        // Extremes of both fields, with a repeated usage that must change
        // nothing. Register 0 spans the whole range and register 63 starts
        // where it ends, so the two intervals touch and both stay live.
        send_word(use_word(4095, 63));
        send_word(use_word(0, 0));
        send_word(use_word(0, 0));
        send_word(use_word(4095, 0));
        send_word(finish_word());

        // Two pairs of equal starts, which go to the lower register first.
        // The first pair has ended before the second pair starts, so the
        // physical registers are handed out again.
        send_word(use_word(10, 5));
        send_word(use_word(20, 5));
        send_word(use_word(21, 9));
        send_word(use_word(25, 9));
        send_word(use_word(21, 3));
        send_word(use_word(30, 3));
        send_word(use_word(12, 7));
        send_word(use_word(10, 7));
        send_word(finish_word());

        // Two short intervals nested in a long one share the second register.
        send_word(use_word(100, 1));
        send_word(use_word(200, 1));
        send_word(use_word(150, 2));
        send_word(use_word(160, 2));
        send_word(use_word(170, 4));
        send_word(use_word(180, 4));
        send_word(finish_word());

        wait_for_results();

        // Random part: each group records some usages in shuffled order and
        // then finishes. Most groups build proper intervals in a window of
        // varying width; a few are pure noise or empty, and the first one
        // makes every register live at once.
        group = 0;
        while (words_sent < ITEM_TARGET)
        begin
            kind = (group == 0) ? 1 : $urandom_range(0, 15);
            case (kind)
                0:
                begin
                    // nothing recorded before the finish
                end
                1:
                begin
                    // All registers start on one statement: 64 results, peak 64.
                    base = $urandom_range(0, 4095);
                    for (int i = 0; i < NUM_VREGS; i++)
                        batch.push_back(use_word(base, i));
                end
                2, 3:
                begin
                    count = $urandom_range(1, 8);
                    for (int i = 0; i < count; i++)
                    begin
                        w = use_word($urandom_range(0, 4095), $urandom_range(0, 63));
                        batch.push_back(w);
                        if ($urandom_range(0, 2) == 0)
                            batch.push_back(w);
                    end
                end
                default:
                begin
                    count = $urandom_range(1, 8);
                    case ($urandom_range(0, 2))
                        0:       span = 31;
                        1:       span = 511;
                        default: span = 4095;
                    endcase
                    base     = $urandom_range(0, 4095 - span);
                    prev_end = base;
                    for (int i = 0; i < count; i++)
                    begin
                        v = $urandom_range(0, 63);
                        // Now and then start exactly where the previous one ended.
                        if ($urandom_range(0, 2) == 0)
                            s = prev_end;
                        else
                            s = base + $urandom_range(0, span);
                        e = s + $urandom_range(0, span / 4 + 1);
                        if (e > 4095)
                            e = 4095;
                        batch.push_back(use_word(s, v));
                        batch.push_back(use_word(e, v));
                        if ($urandom_range(0, 1) == 0)
                            batch.push_back(use_word((s + e) / 2, v));
                        if ($urandom_range(0, 3) == 0)
                            batch.push_back(use_word(s, v));
                        prev_end = e;
                    end
                end
            endcase

            while (batch.size() > 0)
            begin
                idx = $urandom_range(0, batch.size() - 1);
                w   = batch[idx];
                batch.delete(idx);
                send_word(w);
            end
            send_word(finish_word());

            if ($urandom_range(0, 7) == 0)
                wait_for_results();
            group++;
        end

        // Let the last allocation drain, then watch a little longer for
        // any word the block should not have sent.
        item_valid <= 1'b0;
        settle = 0;
        @(posedge clk);
        while (words_due != 0 && settle < DRAIN_LIMIT)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && words_due == 0)
            $display("tb_linear_scan_register_allocator passed");
        else
            $display("tb_linear_scan_register_allocator failed");
        $finish;
    end

endmodule
